// File: src/macfh_pkg.sv
// Package with payload types and constants for the name-hash MAC address generator.
`timescale 1ns / 1ps

package macfh_pkg;

   localparam logic [31:0] FNV_BASIS    = 32'h811C_9DC5;
   localparam logic [31:0] FNV_PRIME    = 32'h0100_0193;
   localparam logic [63:0] SEED_MIX     = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] LCG_MUL      = 64'h5851_F42D_4C95_7F2D;
   localparam logic [63:0] LCG_ADD      = 64'h1405_7B7E_F767_814F;
   localparam logic [7:0]  LOCAL_BIT    = 8'h02;
   localparam logic [7:0]  UNICAST_MASK = 8'hFE;
   localparam logic [2:0]  FIRST_OCTET  = 3'd0;
   localparam logic [2:0]  FINAL_OCTET  = 3'd5;

   typedef struct packed {
      logic [7:0]  name_byte;
      logic        has_byte;
      logic [15:0] port;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [7:0] mac_byte;
      logic [2:0] octet_index;
      logic       last_octet;
   } rsp_type;

endpackage

// File: src/macfh_mul.sv
// Shared 32 by 32 bit multiplier with a registered 64-bit product.
`timescale 1ns / 1ps

module macfh_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] product
);

   logic [63:0] product_ff;
   logic [63:0] product_in;

   assign product_in = {32'd0, mul_a} * {32'd0, mul_b};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: src/mac_address_from_name_hash_top.sv
// Top level of the generator that derives a MAC address from a node name and a port.
//
// Name bytes enter one item at a time on the req_ channel. Each present, nonzero byte
// is folded into a 32-bit FNV-1a hash. An item with last set closes the name: a
// 64-bit seed is built from the hash and the port, and six 64-bit LCG steps each
// send one address octet out on the rsp_ channel, octet 0 first. Octet 0 is forced
// to a locally administered unicast value. The hash returns to its offset basis as
// the seed is built. An item that is not last is accepted, multiplied and written
// back; without a byte it is only accepted. A last item goes on to the seed, then
// through states L0 to L4 and an emit state for each octet, on the single shared
// 32 by 32 multiplier that builds each 64-bit product from three partial products.
// req_stall is high while an item is being worked on. When rsp_stall holds an octet,
// the sequencer waits at that octet and resumes when it is taken. Reset clears the
// sequencer and the output valid, and loads the hash with its offset basis and the
// generator state with zero.
`timescale 1ns / 1ps

module mac_address_from_name_hash_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  macfh_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output macfh_pkg::rsp_type rsp_data
);

   import macfh_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_HMUL = 4'd1;
   localparam logic [3:0] ST_HWB  = 4'd2;
   localparam logic [3:0] ST_SEED = 4'd3;
   localparam logic [3:0] ST_L0   = 4'd4;
   localparam logic [3:0] ST_L1   = 4'd5;
   localparam logic [3:0] ST_L2   = 4'd6;
   localparam logic [3:0] ST_L3   = 4'd7;
   localparam logic [3:0] ST_L4   = 4'd8;
   localparam logic [3:0] ST_EMIT = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [31:0] hash_ff, hash_in;
   logic [63:0] gen_ff, gen_in;
   logic [63:0] acc_ff, acc_in;
   logic [2:0]  count_ff, count_in;
   logic [15:0] port_ff, port_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] product;
   logic        req_fire;
   logic        byte_used;
   logic        out_free;
   logic [7:0]  octet;

   macfh_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign req_fire  = req_valid && !req_stall;
   assign byte_used = req_data.has_byte && (req_data.name_byte != 8'd0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign octet     = (count_ff == FIRST_OCTET) ?
                      ((gen_ff[63:56] | LOCAL_BIT) & UNICAST_MASK) : gen_ff[63:56];

   always_comb begin
      case (state_ff)
         ST_HMUL: begin
            mul_a = hash_ff;
            mul_b = FNV_PRIME;
         end
         ST_L1: begin
            mul_a = gen_ff[63:32];
            mul_b = LCG_MUL[31:0];
         end
         ST_L2: begin
            mul_a = gen_ff[31:0];
            mul_b = LCG_MUL[63:32];
         end
         default: begin
            mul_a = gen_ff[31:0];
            mul_b = LCG_MUL[31:0];
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      gen_in       = gen_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      port_in      = port_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               port_in = req_data.port;
               last_in = req_data.last;
               if (byte_used) begin
                  hash_in  = hash_ff ^ {24'd0, req_data.name_byte};
                  state_in = ST_HMUL;
               end else if (req_data.last) begin
                  state_in = ST_SEED;
               end
            end
         end
         ST_HMUL: begin
            state_in = ST_HWB;
         end
         ST_HWB: begin
            hash_in  = product[31:0];
            state_in = last_ff ? ST_SEED : ST_IDLE;
         end
         ST_SEED: begin
            gen_in   = {16'd0, hash_ff, 16'd0} ^ {48'd0, port_ff} ^ SEED_MIX;
            hash_in  = FNV_BASIS;
            count_in = FIRST_OCTET;
            state_in = ST_L0;
         end
         ST_L0: begin
            state_in = ST_L1;
         end
         ST_L1: begin
            acc_in   = product;
            state_in = ST_L2;
         end
         ST_L2: begin
            acc_in   = {acc_ff[63:32] + product[31:0], acc_ff[31:0]};
            state_in = ST_L3;
         end
         ST_L3: begin
            acc_in   = {acc_ff[63:32] + product[31:0], acc_ff[31:0]};
            state_in = ST_L4;
         end
         ST_L4: begin
            gen_in   = acc_ff + LCG_ADD;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.mac_byte    = octet;
               rsp_data_in.octet_index = count_ff;
               rsp_data_in.last_octet  = (count_ff == FINAL_OCTET);
               if (count_ff == FINAL_OCTET) begin
                  count_in = FIRST_OCTET;
                  state_in = ST_IDLE;
               end else begin
                  count_in = count_ff + 3'd1;
                  state_in = ST_L0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= FNV_BASIS;
         gen_ff       <= 64'd0;
         count_ff     <= FIRST_OCTET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         gen_ff       <= gen_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      port_ff     <= port_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FINAL_OCTET)
      else $error("Octet counter left its range.");

   a_hash_restart: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEED |=> hash_ff == FNV_BASIS)
      else $error("Hash did not return to its offset basis after the seed.");

   a_first_octet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.octet_index == FIRST_OCTET |->
      rsp_data_ff.mac_byte[1] && !rsp_data_ff.mac_byte[0])
      else $error("First octet is not a locally administered unicast value.");

   a_final_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
      rsp_data_ff.last_octet == (rsp_data_ff.octet_index == FINAL_OCTET))
      else $error("Final octet flag disagrees with the octet index.");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free && count_ff == FINAL_OCTET |=>
      state_ff == ST_IDLE && rsp_data_ff.last_octet)
      else $error("Sequencer did not return to idle after the final octet.");

endmodule
